// ===== rtl/core/xdx_pkg.sv =====
package xdx_pkg;

  localparam int unsigned MaxRunLength = 1048576;
  localparam int unsigned StepWidth    = 21;
  localparam int unsigned ScoreWidth   = 32;
  localparam int unsigned MatchWidth   = 8;
  localparam int unsigned XdropWidth   = 16;
  localparam int unsigned CodeWidth    = 3;

  localparam logic [StepWidth-1:0] MaxSteps = StepWidth'(MaxRunLength);

  localparam logic [CodeWidth-1:0] CodeSep = 3'd4;
  localparam logic [CodeWidth-1:0] CodeGap = 3'd5;

  localparam logic [ScoreWidth-1:0] ScoreMax = 32'h7fff_ffff;
  localparam logic [ScoreWidth-1:0] ScoreMin = 32'h8000_0000;

  typedef enum logic {
    MODE_RESCORE = 1'b0,
    MODE_EXTEND  = 1'b1
  } run_mode_t;

  typedef enum logic [1:0] {
    STOP_LAST  = 2'd0,
    STOP_SEP   = 2'd1,
    STOP_XDROP = 2'd2
  } stop_cause_t;

  typedef enum logic {
    REG_MATCH_SCORE = 1'b0,
    REG_X_DROP      = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ScoreWidth-1:0] running_score;
    logic signed [ScoreWidth-1:0] best_gain;
    logic [StepWidth-1:0]         step_count;
    logic [StepWidth-1:0]         best_step;
    logic                         run_active;
    run_mode_t                    run_mode;
  } xdx_state_t;

  typedef struct packed {
    run_mode_t            op;
    logic [CodeWidth-1:0] base_a;
    logic [CodeWidth-1:0] base_b;
    logic                 first;
    logic                 last;
  } xdx_item_t;

  typedef struct packed {
    logic signed [ScoreWidth-1:0] total_score;
    logic [StepWidth-1:0]         best_steps;
    stop_cause_t                  stop_cause;
  } xdx_result_t;

endpackage

// ===== rtl/core/ungapped_xdrop_extension.sv =====
// Ungapped X-drop extension scorer.
// Aligned base pairs arrive on the s_ channel, one pair per transaction:
// tdata carries the two base codes, tuser the mode and the run-start flag,
// and tlast marks the last pair of the sequence or region. A pair with the
// start flag opens a run in rescore or extend mode. Each run yields one
// result on the m_ channel: the total or best gain, the step of the best
// match and the stop cause.
// The match score and X-drop registers are written through cfg_we,
// cfg_addr and cfg_wdata; the user must write them only while no run is in
// flight, which the block itself does not enforce. One pair is taken every
// cycle while s_tready is high. A pair is held in the input register while
// the score add, saturation and best-score compare update the run state and
// load the result register, which then presents the result of the run.
// When the receiver holds m_tready low, the result register keeps its
// transaction and s_tready drops once the input register is also full.
// Synchronous reset clears both registers and the run state and loads the
// register defaults of match score 1 and X-drop 20.
module ungapped_xdrop_extension (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // base_a[2:0], base_b[5:3], zero pad [7:6]
  input  logic [1:0]  s_tuser,   // op[0], first[1]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // total_score[31:0], best_steps[52:32], stop_cause[54:53], pad
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import xdx_pkg::*;

  logic [MatchWidth-1:0] match_score;
  logic [XdropWidth-1:0] x_drop;

  logic        in_valid;
  xdx_item_t   in_item;
  xdx_state_t  state;
  xdx_state_t  state_next;
  logic        emit;
  xdx_result_t result;
  logic        out_valid;
  xdx_result_t out_result;
  logic        advance;
  logic        fire;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign fire     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_score <= MatchWidth'(1);
      x_drop      <= XdropWidth'(20);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_MATCH_SCORE: match_score <= cfg_wdata[MatchWidth-1:0];
        REG_X_DROP:      x_drop      <= cfg_wdata[XdropWidth-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.op     <= run_mode_t'(s_tuser[0]);
      in_item.first  <= s_tuser[1];
      in_item.base_a <= s_tdata[2:0];
      in_item.base_b <= s_tdata[5:3];
      in_item.last   <= s_tlast;
    end
  end

  xdx_step u_step (
    .state       (state),
    .item        (in_item),
    .match_score (match_score),
    .x_drop      (x_drop),
    .state_next  (state_next),
    .emit        (emit),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_result.stop_cause, out_result.best_steps,
                     out_result.total_score};

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state.step_count <= MaxSteps)
    else $error("step count passed the run length bound");

  a_best_step: assert property (@(posedge clk) disable iff (rst)
    state.best_step <= state.step_count)
    else $error("best step lies beyond the current step");

  a_best_nonneg: assert property (@(posedge clk) disable iff (rst)
    !state.best_gain[ScoreWidth-1])
    else $error("best gain went negative");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (fire && emit) |=> !state.run_active)
    else $error("run still active after its result");

  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_result.stop_cause == STOP_LAST ||
                   out_result.stop_cause == STOP_SEP ||
                   out_result.stop_cause == STOP_XDROP))
    else $error("result carries an unknown stop cause");

endmodule

// ===== rtl/core/xdx_step.sv =====
module xdx_step (
  input  xdx_pkg::xdx_state_t              state,
  input  xdx_pkg::xdx_item_t               item,
  input  logic [xdx_pkg::MatchWidth-1:0]   match_score,
  input  logic [xdx_pkg::XdropWidth-1:0]   x_drop,
  output xdx_pkg::xdx_state_t              state_next,
  output logic                             emit,
  output xdx_pkg::xdx_result_t             result
);
  import xdx_pkg::*;

  logic                         active;
  run_mode_t                    mode;
  logic signed [ScoreWidth-1:0] rs;
  logic signed [ScoreWidth-1:0] best;
  logic [StepWidth-1:0]         sc_in;
  logic [StepWidth-1:0]         bstep;
  logic [StepWidth-1:0]         sc1;
  logic                         last_eff;
  logic                         gap;
  logic                         sep;
  logic                         equal;
  logic signed [ScoreWidth:0]   sum;
  logic signed [ScoreWidth-1:0] rs_new;
  logic signed [ScoreWidth+1:0] thr;

  assign active = item.first | state.run_active;
  assign mode   = item.first ? item.op : state.run_mode;
  assign rs     = item.first ? '0 : state.running_score;
  assign best   = item.first ? '0 : state.best_gain;
  assign sc_in  = item.first ? '0 : state.step_count;
  assign bstep  = item.first ? '0 : state.best_step;

  assign sc1      = (sc_in < MaxSteps) ? sc_in + StepWidth'(1) : sc_in;
  assign last_eff = item.last | (sc1 >= MaxSteps);

  assign gap   = (item.base_a >= CodeGap) | (item.base_b >= CodeGap);
  assign sep   = (item.base_a == CodeSep) | (item.base_b == CodeSep);
  assign equal = (item.base_a == item.base_b);

  always_comb begin
    if (equal) begin
      sum = {rs[ScoreWidth-1], rs} + $signed({1'b0, {(ScoreWidth-MatchWidth){1'b0}},
                                                match_score});
    end else begin
      sum = {rs[ScoreWidth-1], rs} - $signed({1'b0, {(ScoreWidth-MatchWidth){1'b0}},
                                                match_score});
    end
    if (sum[ScoreWidth] != sum[ScoreWidth-1]) begin
      rs_new = sum[ScoreWidth] ? ScoreMin : ScoreMax;
    end else begin
      rs_new = sum[ScoreWidth-1:0];
    end
  end

  // The X-drop bound uses the best score before this pair; a mismatch never raises it.
  assign thr = {{2{best[ScoreWidth-1]}}, best}
             - $signed({2'b00, {(ScoreWidth-XdropWidth){1'b0}}, x_drop});

  always_comb begin
    state_next          = state;
    emit                = 1'b0;
    result.total_score  = best;
    result.best_steps   = bstep;
    result.stop_cause   = STOP_LAST;
    if (active) begin
      state_next.run_active    = 1'b1;
      state_next.run_mode      = mode;
      state_next.running_score = rs;
      state_next.best_gain     = best;
      state_next.step_count    = sc1;
      state_next.best_step     = bstep;
      if (mode == MODE_RESCORE) begin
        if (!gap) begin
          state_next.running_score = rs_new;
        end
        if (last_eff) begin
          emit               = 1'b1;
          result.total_score = gap ? rs : rs_new;
          result.best_steps  = '0;
          result.stop_cause  = STOP_LAST;
        end
      end else begin
        if (!gap && sep) begin
          emit              = 1'b1;
          result.stop_cause = STOP_SEP;
        end else if (!gap && equal) begin
          state_next.running_score = rs_new;
          if (rs_new > best) begin
            state_next.best_gain = rs_new;
            state_next.best_step = sc1;
            result.total_score   = rs_new;
            result.best_steps    = sc1;
          end
          if (last_eff) begin
            emit = 1'b1;
          end
        end else if (!gap) begin
          state_next.running_score = rs_new;
          if ($signed({{2{rs_new[ScoreWidth-1]}}, rs_new}) < thr) begin
            emit              = 1'b1;
            result.stop_cause = STOP_XDROP;
          end else if (last_eff) begin
            emit = 1'b1;
          end
        end else if (last_eff) begin
          emit = 1'b1;
        end
      end
      if (emit) begin
        state_next.run_active = 1'b0;
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xdx_pkg::*;

  localparam int QuietLimit = 3000;
  localparam int LongHold   = 400;
  localparam int SettleCycles = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = '0;

  ungapped_xdrop_extension uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Scoring state mirrored from the block.
  logic [MatchWidth-1:0]        match_pts = 8'd1;
  logic [XdropWidth-1:0]        drop_limit = 16'd20;
  logic signed [ScoreWidth-1:0] run_score = '0;
  logic signed [ScoreWidth-1:0] best_gain = '0;
  logic [StepWidth-1:0]         step_no = '0;
  logic [StepWidth-1:0]         best_step = '0;
  logic                         in_run = 1'b0;
  run_mode_t                    run_kind = MODE_RESCORE;

  xdx_item_t   pairs_to_send[$];
  xdx_result_t scores_due[$];
  xdx_item_t   next_pair;

  int n_queued = 0;
  int n_accepted = 0;
  int failures = 0;
  int quiet_cycles = 0;
  int max_in_gap = 0;
  int max_out_gap = 0;
  int in_wait = 0;
  int out_wait = 0;
  int hold_left = 0;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  bit in_fire = 1'b0;
  bit out_fire = 1'b0;

  function automatic logic signed [ScoreWidth-1:0] add_sat(
      input logic signed [ScoreWidth-1:0] score, input bit up);
    longint sum;
    sum = up ? longint'(score) + longint'(match_pts) : longint'(score) - longint'(match_pts);
    if (sum > 64'sd2147483647) return ScoreMax;
    if (sum < -64'sd2147483648) return ScoreMin;
    return sum[ScoreWidth-1:0];
  endfunction

  function automatic bit score_pair(input xdx_item_t pair, output xdx_result_t res);
    bit          is_gap;
    bit          is_sep;
    bit          done;
    stop_cause_t cause;
    res = '0;
    is_gap = pair.base_a >= CodeGap || pair.base_b >= CodeGap;
    is_sep = pair.base_a == CodeSep || pair.base_b == CodeSep;
    done = pair.last;
    cause = STOP_LAST;
    if (pair.first) begin
      run_score = '0;
      best_gain = '0;
      step_no = '0;
      best_step = '0;
      in_run = 1'b1;
      run_kind = pair.op;
    end
    if (!in_run) return 1'b0;
    if (step_no < MaxSteps) step_no++;
    if (step_no >= MaxSteps) done = 1'b1;
    if (run_kind == MODE_RESCORE) begin
      if (!is_gap) run_score = add_sat(run_score, pair.base_a == pair.base_b);
      if (done) begin
        res.total_score = run_score;
        res.stop_cause = STOP_LAST;
        in_run = 1'b0;
      end
      return done;
    end
    if (!is_gap) begin
      if (is_sep) begin
        done = 1'b1;
        cause = STOP_SEP;
      end else if (pair.base_a == pair.base_b) begin
        run_score = add_sat(run_score, 1'b1);
        if (run_score > best_gain) begin
          best_gain = run_score;
          best_step = step_no;
        end
      end else begin
        run_score = add_sat(run_score, 1'b0);
        if (longint'(run_score) < longint'(best_gain) - longint'(drop_limit)) begin
          done = 1'b1;
          cause = STOP_XDROP;
        end
      end
    end
    if (done) begin
      res.total_score = best_gain;
      res.best_steps = best_step;
      res.stop_cause = cause;
      in_run = 1'b0;
    end
    return done;
  endfunction

  // Input driver.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      in_wait = 0;
    end else if (!s_tvalid || in_fire) begin
      if (in_wait > 0) begin
        in_wait--;
        s_tvalid <= 1'b0;
      end else if (pairs_to_send.size() != 0) begin
        next_pair = pairs_to_send.pop_front();
        s_tdata <= {2'b00, next_pair.base_b, next_pair.base_a};
        s_tuser <= {next_pair.first, next_pair.op};
        s_tlast <= next_pair.last;
        s_tvalid <= 1'b1;
        in_wait = $urandom_range(0, max_in_gap);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      out_wait = 0;
    end else begin
      if (long_hold_req && !long_hold_done) begin
        hold_left = LongHold;
        long_hold_done = 1'b1;
      end
      if (out_fire) out_wait = $urandom_range(0, max_out_gap);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor, checker and watchdog.
  always @(posedge clk) begin
    xdx_item_t   pair;
    xdx_result_t res;
    xdx_result_t want;
    logic signed [ScoreWidth-1:0] got_total;
    logic [StepWidth-1:0]         got_steps;
    logic [1:0]                   got_cause;
    if (rst) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      out_fire <= m_tvalid && m_tready;
      if (s_tvalid && s_tready) begin
        n_accepted++;
        pair.op = run_mode_t'(s_tuser[0]);
        pair.first = s_tuser[1];
        pair.base_a = s_tdata[2:0];
        pair.base_b = s_tdata[5:3];
        pair.last = s_tlast;
        if (score_pair(pair, res)) scores_due.push_back(res);
      end
      if (m_tvalid && m_tready) begin
        got_total = m_tdata[31:0];
        got_steps = m_tdata[52:32];
        got_cause = m_tdata[54:53];
        if (scores_due.size() == 0) begin
          $display("%0t: unexpected result total %0d steps %0d cause %0d",
                   $time, got_total, got_steps, got_cause);
          failures++;
        end else begin
          want = scores_due.pop_front();
          if (got_total !== want.total_score) begin
            $display("%0t: total_score expected %0d, actual %0d",
                     $time, want.total_score, got_total);
            failures++;
          end
          if (got_steps !== want.best_steps) begin
            $display("%0t: best_steps expected %0d, actual %0d",
                     $time, want.best_steps, got_steps);
            failures++;
          end
          if (got_cause !== want.stop_cause) begin
            $display("%0t: stop_cause expected %0d, actual %0d",
                     $time, want.stop_cause, got_cause);
            failures++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic queue_pair(input run_mode_t op, input logic [2:0] a, input logic [2:0] b,
                            input bit first, input bit last);
    xdx_item_t pair;
    pair.op = op;
    pair.base_a = a;
    pair.base_b = b;
    pair.first = first;
    pair.last = last;
    pairs_to_send.push_back(pair);
    n_queued++;
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || scores_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MATCH_SCORE) match_pts = value[MatchWidth-1:0];
    else drop_limit = value;
  endtask

  task automatic queue_run(input run_mode_t op, input int len, input bit closed);
    logic [2:0] a;
    logic [2:0] b;
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      a = 3'($urandom_range(0, 3));
      b = a;
      if (r >= 60 && r < 78) begin
        b = 3'($urandom_range(0, 3));
      end else if (r >= 78 && r < 88) begin
        a = 3'($urandom_range(0, 7));
        b = 3'($urandom_range(5, 7));
      end else if (r >= 88 && r < 95) begin
        a = 3'($urandom_range(5, 7));
        b = 3'($urandom_range(0, 7));
      end else if (r >= 95) begin
        if ($urandom_range(0, 1)) a = CodeSep;
        else b = CodeSep;
      end
      queue_pair(op, a, b, i == 0, closed && i == len - 1);
    end
  endtask

  task automatic queue_random_pairs(input int count);
    int sent;
    int len;
    int kind;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
      if (kind == 0) begin
        queue_pair(run_mode_t'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        len = 1;
      end else begin
        queue_run(run_mode_t'($urandom_range(0, 1)), len, kind != 1);
      end
      sent += len;
    end
  endtask

  initial begin
    int match_set[7];
    int drop_set[7];
    match_set = '{7, 1, 255, 1, 0, 3, 0};
    drop_set  = '{20, 0, 65535, 65535, 0, 3, 0};
    match_set[4] = $urandom_range(1, 255);
    drop_set[4]  = $urandom_range(0, 65535);
    match_set[6] = $urandom_range(1, 16);
    drop_set[6]  = $urandom_range(0, 600);

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    max_in_gap = 3;
    max_out_gap = 3;
    // Defaults after reset: idle pair, rescore with gaps and separators, extensions.
    queue_pair(MODE_EXTEND, 3'd1, 3'd1, 1'b0, 1'b1);
    queue_pair(MODE_RESCORE, 3'd0, 3'd0, 1'b1, 1'b0);
    queue_pair(MODE_EXTEND, 3'd1, 3'd2, 1'b0, 1'b0);
    queue_pair(MODE_EXTEND, 3'd5, 3'd3, 1'b0, 1'b0);
    queue_pair(MODE_RESCORE, 3'd4, 3'd4, 1'b0, 1'b0);
    queue_pair(MODE_RESCORE, 3'd4, 3'd1, 1'b0, 1'b0);
    queue_pair(MODE_RESCORE, 3'd7, 3'd6, 1'b0, 1'b0);
    queue_pair(MODE_RESCORE, 3'd3, 3'd3, 1'b0, 1'b1);
    queue_pair(MODE_EXTEND, 3'd2, 3'd2, 1'b1, 1'b0);
    queue_pair(MODE_RESCORE, 3'd1, 3'd1, 1'b0, 1'b0);
    queue_pair(MODE_EXTEND, 3'd6, 3'd0, 1'b0, 1'b0);
    queue_pair(MODE_EXTEND, 3'd3, 3'd0, 1'b0, 1'b0);
    queue_pair(MODE_EXTEND, 3'd4, 3'd2, 1'b0, 1'b0);
    queue_pair(MODE_EXTEND, 3'd5, 3'd5, 1'b1, 1'b1);
    wait_idle();

    write_reg(REG_MATCH_SCORE, 16'd255);
    write_reg(REG_X_DROP, 16'd0);
    queue_pair(MODE_EXTEND, 3'd0, 3'd0, 1'b1, 1'b0);
    queue_pair(MODE_EXTEND, 3'd1, 3'd2, 1'b0, 1'b0);
    queue_pair(MODE_EXTEND, 3'd3, 3'd3, 1'b1, 1'b0);
    queue_pair(MODE_EXTEND, 3'd2, 3'd1, 1'b0, 1'b1);
    queue_pair(MODE_EXTEND, 3'd0, 3'd0, 1'b1, 1'b0);
    queue_pair(MODE_EXTEND, 3'd1, 3'd4, 1'b0, 1'b1);
    queue_pair(MODE_EXTEND, 3'd0, 3'd1, 1'b1, 1'b1);
    queue_pair(MODE_RESCORE, 3'd2, 3'd1, 1'b1, 1'b0);
    queue_pair(MODE_RESCORE, 3'd0, 3'd3, 1'b0, 1'b1);
    wait_idle();

    write_reg(REG_X_DROP, 16'd65535);
    queue_pair(MODE_EXTEND, 3'd0, 3'd1, 1'b1, 1'b0);
    queue_pair(MODE_EXTEND, 3'd3, 3'd2, 1'b0, 1'b0);
    queue_pair(MODE_EXTEND, 3'd2, 3'd2, 1'b0, 1'b1);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      write_reg(REG_MATCH_SCORE, 16'(match_set[p]));
      write_reg(REG_X_DROP, 16'(drop_set[p]));
      max_in_gap = (p % 3 == 0) ? 16 : (p % 3 == 1) ? 4 : 0;
      max_out_gap = (p % 3 == 2) ? 16 : (p % 3 == 0) ? 3 : 0;
      if (p == 1) long_hold_req = 1'b1;
      queue_random_pairs(190);
      wait_idle();
    end

    repeat (20) @(negedge clk);

    if (scores_due.size() != 0) failures++;
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
